FILE: src/gcjm_pkg.sv
package gcjm_pkg;

	// Table size and the widths that follow from it
	localparam int MAX_JETS   = 64;
	localparam int SLOT_W     = $clog2(MAX_JETS);
	localparam int FILL_W     = $clog2(MAX_JETS + 1);

	// Field widths
	localparam int MODE_W     = 2;
	localparam int ET_W       = 16;
	localparam int ETA_W      = 14;
	localparam int PHI_W      = 13;
	localparam int JET_W      = ET_W + ETA_W + PHI_W;
	localparam int CONE_W     = 14;
	localparam int OUT_SLOT_W = 6;
	localparam int OUT_DIST_W = 26;
	localparam int IN_TDATA_W  = ((JET_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = OUT_SLOT_W + ET_W + ETA_W + PHI_W + OUT_DIST_W + ET_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// Distance arithmetic
	localparam int DE_W     = ETA_W + 1;          // eta difference
	localparam int DP_W     = PHI_W + 1;          // phi difference, folded
	localparam int DE_SQ_W  = 2 * ETA_W;          // |de| < 2^ETA_W
	localparam int DP_SQ_W  = 24;                 // folded |dp| <= pi < 2^12
	localparam int DIST_W   = DE_SQ_W + 1;
	localparam int BEST_W   = 27;                 // cone^2 <= 2^26
	localparam int PI_Q     = 3217;
	localparam int TWO_PI_Q = 6434;
	localparam int CONE_CAP = 8192;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REF_ET_MIN  = 2'd0,
		CFG_MEAS_ET_MIN = 2'd1,
		CFG_CONE_RADIUS = 2'd2
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic              load_we;
		logic              clr;
		logic              q_start;
		logic              issue;
		logic [SLOT_W-1:0] issue_addr;
		logic              out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              qry_pass;
		logic              pipe_empty;
		logic              out_free;
	} status_t;

endpackage

FILE: src/greedy_cone_jet_matcher.sv
// Greedy cone jet matcher. Each input word carries a kind in s_tuser: load
// stores a measured jet in the next unused slot (ignored once 64 are stored),
// new event empties the table, query matches a reference jet. A query whose
// ET passes ref_et_min yields exactly one result word; it names the nearest
// stored jet (ET >= meas_et_min, squared eta-phi distance below the square
// of cone_radius capped at 8192, earliest slot on a tie), which is then
// removed from the table, or reports unmatched. Load, new event, unused kinds
// and a query that fails ref_et_min leave the input ready. A passing query
// holds the input while the table is read one slot per cycle, slots 0 to
// fill count minus one, through its single read port; then the distance
// stages drain and the word is moved to the output register once it is free.
// The output register lets the block take further words while a result
// waits; configuration writes are taken in any cycle.
module greedy_cone_jet_matcher (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input words
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// jet_et[15:0], jet_eta[29:16], jet_phi[42:30], zero fill
	input  logic [gcjm_pkg::IN_TDATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [gcjm_pkg::MODE_W-1:0]      s_tuser,
	// Result words
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// match_slot[5:0], match_et[21:6], match_eta[35:22], match_phi[48:36],
	// dist_sq[74:49], ref_et[90:75], zero fill
	output logic [gcjm_pkg::OUT_TDATA_W-1:0] m_tdata,
	// matched[0]
	output logic                             m_tuser,
	// Configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gcjm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcjm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	gcjm_pkg::cmd_t    cmd;
	gcjm_pkg::status_t st;

	assign cfg_ready = 1'b1;

	gcjm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	gcjm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

FILE: src/gcjm_ctrl.sv
module gcjm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [gcjm_pkg::MODE_W-1:0]  s_tuser,
	input  gcjm_pkg::status_t            st,
	output gcjm_pkg::cmd_t               cmd
);

	gcjm_pkg::state_t              state_q;
	logic [gcjm_pkg::FILL_W-1:0]   scan_q;
	logic                          acc;
	logic                          more;

	assign s_tready = (state_q == gcjm_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign more     = (scan_q != st.fill);

	// Decode commands
	always_comb begin
		cmd            = '0;
		cmd.load_we    = acc && (s_tuser == gcjm_pkg::MODE_LOAD);
		cmd.clr        = acc && (s_tuser == gcjm_pkg::MODE_CLEAR);
		cmd.q_start    = acc && (s_tuser == gcjm_pkg::MODE_QUERY) && st.qry_pass;
		cmd.issue      = (state_q == gcjm_pkg::ST_SCAN) && more;
		cmd.issue_addr = scan_q[gcjm_pkg::SLOT_W-1:0];
		cmd.out_load   = (state_q == gcjm_pkg::ST_DONE) && st.out_free;
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcjm_pkg::ST_IDLE;
			scan_q  <= '0;
		end else begin
			case (state_q)
				gcjm_pkg::ST_IDLE: begin
					if (cmd.q_start) begin
						scan_q  <= '0;
						state_q <= gcjm_pkg::ST_SCAN;
					end
				end
				gcjm_pkg::ST_SCAN: begin
					if (more) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= gcjm_pkg::ST_DRAIN;
					end
				end
				gcjm_pkg::ST_DRAIN: begin
					if (st.pipe_empty) begin
						state_q <= gcjm_pkg::ST_DONE;
					end
				end
				gcjm_pkg::ST_DONE: begin
					if (st.out_free) begin
						state_q <= gcjm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gcjm_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/gcjm_dp.sv
module gcjm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gcjm_pkg::cmd_t                   cmd,
	output gcjm_pkg::status_t                st,
	input  logic [gcjm_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             cfg_valid,
	input  logic [gcjm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcjm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gcjm_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tuser
);

	localparam int ET_W   = gcjm_pkg::ET_W;
	localparam int ETA_W  = gcjm_pkg::ETA_W;
	localparam int PHI_W  = gcjm_pkg::PHI_W;
	localparam int JET_W  = gcjm_pkg::JET_W;
	localparam int SLOT_W = gcjm_pkg::SLOT_W;
	localparam int PAD_W  = gcjm_pkg::OUT_TDATA_W - gcjm_pkg::OUT_FIELD_W;

	// Configuration registers
	logic [ET_W-1:0]             ref_et_min_q;
	logic [ET_W-1:0]             meas_et_min_q;
	logic [gcjm_pkg::CONE_W-1:0] cone_q;

	// Table, valid bits, fill count
	logic [JET_W-1:0]            mem [gcjm_pkg::MAX_JETS];
	logic [gcjm_pkg::MAX_JETS-1:0] valid_q;
	logic [gcjm_pkg::FILL_W-1:0] fill_q;
	logic                        room;

	// Reference jet of the current query
	logic [ET_W-1:0]             ref_et_q;
	logic signed [ETA_W-1:0]     ref_eta_q;
	logic signed [PHI_W-1:0]     ref_phi_q;

	// Scan pipeline
	logic                        v_s1, v_s2, v_s3;
	logic [SLOT_W-1:0]           slot_s1, slot_s2, slot_s3;
	logic [JET_W-1:0]            rd_s1, jet_s2, jet_s3;
	logic signed [gcjm_pkg::DE_W-1:0] de_s2;
	logic signed [gcjm_pkg::DP_W-1:0] dp_s2;
	logic [gcjm_pkg::DE_SQ_W-1:0] de_sq_s3;
	logic [gcjm_pkg::DP_SQ_W-1:0] dp_sq_s3;

	// Best candidate
	logic                        found_q;
	logic [gcjm_pkg::BEST_W-1:0] best_q;
	logic [SLOT_W-1:0]           best_slot_q;
	logic [JET_W-1:0]            best_jet_q;

	// Output register
	logic                        out_v_q;
	logic                        out_matched_q;
	logic [gcjm_pkg::OUT_SLOT_W-1:0] out_slot_q;
	logic [JET_W-1:0]            out_jet_q;
	logic [gcjm_pkg::OUT_DIST_W-1:0] out_dist_q;
	logic [ET_W-1:0]             out_ref_et_q;

	// Combinational terms
	logic [ET_W-1:0]             in_et;
	logic signed [ETA_W-1:0]     rd_eta;
	logic signed [PHI_W-1:0]     rd_phi;
	logic signed [gcjm_pkg::DE_W-1:0] de_c;
	logic signed [gcjm_pkg::DP_W-1:0] dp_raw;
	logic [PHI_W-1:0]            dp_abs;
	logic signed [gcjm_pkg::DP_W-1:0] dp_fold;
	logic signed [2*gcjm_pkg::DE_W-1:0] de_sq_c;
	logic signed [2*gcjm_pkg::DP_W-1:0] dp_sq_c;
	logic [gcjm_pkg::DIST_W-1:0] dist_c;
	logic [gcjm_pkg::CONE_W-1:0] cone_cap_c;
	logic [2*gcjm_pkg::CONE_W-1:0] cone_sq_c;
	logic                        better;

	assign in_et = s_tdata[ET_W-1:0];
	assign room  = (fill_q < gcjm_pkg::FILL_W'(gcjm_pkg::MAX_JETS));

	assign st.fill       = fill_q;
	assign st.qry_pass   = (in_et >= ref_et_min_q);
	assign st.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign st.out_free   = !out_v_q || m_tready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_et_min_q  <= '0;
			meas_et_min_q <= '0;
			cone_q        <= gcjm_pkg::CONE_W'(512);
		end else if (cfg_valid) begin
			case (cfg_index)
				gcjm_pkg::CFG_REF_ET_MIN:  ref_et_min_q  <= cfg_data[ET_W-1:0];
				gcjm_pkg::CFG_MEAS_ET_MIN: meas_et_min_q <= cfg_data[ET_W-1:0];
				gcjm_pkg::CFG_CONE_RADIUS: cone_q <= cfg_data[gcjm_pkg::CONE_W-1:0];
				default: ;
			endcase
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_we && room) begin
			mem[fill_q[SLOT_W-1:0]] <= s_tdata[JET_W-1:0];
		end
		rd_s1 <= mem[cmd.issue_addr];
	end

	// Track valid slots and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (cmd.clr) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.load_we && room) begin
				valid_q[fill_q[SLOT_W-1:0]] <= 1'b1;
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.out_load && found_q) begin
				valid_q[best_slot_q] <= 1'b0;
			end
		end
	end

	// Stage 2 terms: eta difference, phi difference folded to at most pi
	assign rd_eta  = rd_s1[ET_W+ETA_W-1:ET_W];
	assign rd_phi  = rd_s1[JET_W-1:ET_W+ETA_W];
	assign de_c    = gcjm_pkg::DE_W'(ref_eta_q) - gcjm_pkg::DE_W'(rd_eta);
	assign dp_raw  = gcjm_pkg::DP_W'(ref_phi_q) - gcjm_pkg::DP_W'(rd_phi);
	assign dp_abs  = dp_raw[gcjm_pkg::DP_W-1] ? PHI_W'(-dp_raw) : PHI_W'(dp_raw);
	assign dp_fold = (dp_abs > PHI_W'(gcjm_pkg::PI_Q))
		? gcjm_pkg::DP_W'(gcjm_pkg::TWO_PI_Q) - gcjm_pkg::DP_W'({1'b0, dp_abs})
		: gcjm_pkg::DP_W'({1'b0, dp_abs});

	// Stage 3 terms: squares
	assign de_sq_c = de_s2 * de_s2;
	assign dp_sq_c = dp_s2 * dp_s2;

	// Compare stage
	assign dist_c = gcjm_pkg::DIST_W'(de_sq_s3) + gcjm_pkg::DIST_W'(dp_sq_s3);
	assign better = v_s3 && (dist_c < gcjm_pkg::DIST_W'(best_q));

	// Cone limit for a new query
	assign cone_cap_c = (cone_q > gcjm_pkg::CONE_W'(gcjm_pkg::CONE_CAP))
		? gcjm_pkg::CONE_W'(gcjm_pkg::CONE_CAP) : cone_q;
	assign cone_sq_c  = cone_cap_c * cone_cap_c;

	// Pipeline qualifiers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && valid_q[cmd.issue_addr];
			v_s2 <= v_s1 && (rd_s1[ET_W-1:0] >= meas_et_min_q);
			v_s3 <= v_s2;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		slot_s1  <= cmd.issue_addr;
		slot_s2  <= slot_s1;
		jet_s2   <= rd_s1;
		de_s2    <= de_c;
		dp_s2    <= dp_fold;
		slot_s3  <= slot_s2;
		jet_s3   <= jet_s2;
		de_sq_s3 <= de_sq_c[gcjm_pkg::DE_SQ_W-1:0];
		dp_sq_s3 <= dp_sq_c[gcjm_pkg::DP_SQ_W-1:0];
	end

	// Latch reference jet and keep the nearest candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.q_start) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			ref_et_q  <= in_et;
			ref_eta_q <= s_tdata[ET_W+ETA_W-1:ET_W];
			ref_phi_q <= s_tdata[JET_W-1:ET_W+ETA_W];
			best_q    <= cone_sq_c[gcjm_pkg::BEST_W-1:0];
		end else if (better) begin
			best_q      <= dist_c[gcjm_pkg::BEST_W-1:0];
			best_slot_q <= slot_s3;
			best_jet_q  <= jet_s3;
		end
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_matched_q <= found_q;
			out_ref_et_q  <= ref_et_q;
			if (found_q) begin
				out_slot_q <= gcjm_pkg::OUT_SLOT_W'(best_slot_q);
				out_jet_q  <= best_jet_q;
				out_dist_q <= best_q[gcjm_pkg::OUT_DIST_W-1:0];
			end else begin
				out_slot_q <= '0;
				out_jet_q  <= '0;
				out_dist_q <= '0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_matched_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_ref_et_q, out_dist_q, out_jet_q, out_slot_q};

endmodule

FILE: src/gcjm_checker.sv
module gcjm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [gcjm_pkg::MODE_W-1:0]      s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [gcjm_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// An unmatched word carries only the reference ET
	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[74:0] == 75'd0)
		else $error("unmatched word has nonzero match fields");

	// No result follows in the cycle right after an accepted word
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

	// Words other than a query keep the input open
	a_nonquery_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != gcjm_pkg::MODE_QUERY) |=> s_tready)
		else $error("input stalled after a non-query word");

endmodule

bind greedy_cone_jet_matcher gcjm_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
